/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* rtl/csq_pkg.sv */
// ----------------------------------------------------------------------------
// csq_pkg
// Types and constants of the counting semaphore with its waiter queue.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam int MaxWaiters = 16;
  localparam int ThreadBits = 8;
  localparam int IdxBits    = $clog2(MaxWaiters);
  localparam int TotalBits  = $clog2(MaxWaiters + 1);
  localparam int CountBits  = 16;

  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DOWN    = 2'd1,
    CMD_UP      = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE         = 3'd0,
    ST_WAIT         = 3'd1,
    ST_RELEASED     = 3'd2,
    ST_NOT_LIVE     = 3'd3,
    ST_ALREADY_LIVE = 3'd4,
    ST_WAITERS      = 3'd5,
    ST_FULL         = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] init_value;
    logic [7:0]  thread_id;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  woken_thread;
    logic [15:0] count_now;
    logic [4:0]  waiters_now;
  } out_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

/* rtl/csq_waitq.sv */
// ----------------------------------------------------------------------------
// csq_waitq
// Circular queue of waiting thread numbers with head, tail and fill count.
// ----------------------------------------------------------------------------
module csq_waitq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  csq_pkg::q_ctrl_t                ctrl_i,
  input  logic [csq_pkg::ThreadBits-1:0]  push_data_i,
  output logic [csq_pkg::ThreadBits-1:0]  head_data_o,
  output logic [csq_pkg::TotalBits-1:0]   total_o
);

  logic [csq_pkg::ThreadBits-1:0] store_q [csq_pkg::MaxWaiters];
  logic [csq_pkg::IdxBits-1:0]    head_q, head_d;
  logic [csq_pkg::IdxBits-1:0]    tail_q, tail_d;
  logic [csq_pkg::TotalBits-1:0]  total_q, total_d;

  function automatic logic [csq_pkg::IdxBits-1:0] next_slot(
    input logic [csq_pkg::IdxBits-1:0] p
  );
    if (p == csq_pkg::IdxBits'(csq_pkg::MaxWaiters - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    total_d = total_q;
    priority if (ctrl_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      total_d = '0;
    end else if (ctrl_i.push) begin
      tail_d  = next_slot(tail_q);
      total_d = total_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = next_slot(head_q);
      total_d = total_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      store_q[tail_q] <= push_data_i;
    end
  end

  assign head_data_o = store_q[head_q];
  assign total_o     = total_q;

endmodule

/* rtl/counting_semaphore_wait_queue_unit.sv */
// Commands pass the input reg, then the result reg; an output stall holds them.
// Throughput: one command per cycle unless the output stalls; each command updates
// the live flag, count or waiter queue in a single pass between the two registers.
// Reset: asynchronous, active low; semaphore not live, count 0, queue empty.
// Waiter entries are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with create/down/up/destroy and a FIFO of waiters.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  csq_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csq_pkg::out_t  out_o
);

  logic            in_vld_q, in_vld_d;
  csq_pkg::in_t    in_q;
  logic            out_vld_q, out_vld_d;
  csq_pkg::out_t   out_q, out_d;
  logic            live_q, live_d;
  logic [csq_pkg::CountBits-1:0] count_q, count_d;

  csq_pkg::q_ctrl_t               q_ctrl;
  logic [csq_pkg::ThreadBits-1:0] head_data;
  logic [csq_pkg::TotalBits-1:0]  total, total_after;
  logic                           advance, accept;
  csq_pkg::status_e               status;
  logic [7:0]                     woken;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  csq_waitq u_waitq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_data_i (in_q.thread_id[csq_pkg::ThreadBits-1:0]),
    .head_data_o (head_data),
    .total_o     (total)
  );

  // Command decode; state only moves when the item leaves the input register.
  always_comb begin
    live_d  = live_q;
    count_d = count_q;
    q_ctrl  = '0;
    status  = csq_pkg::ST_DONE;
    woken   = '0;
    if (in_q.cmd != csq_pkg::CMD_CREATE && !live_q) begin
      status = csq_pkg::ST_NOT_LIVE;
    end else begin
      unique case (in_q.cmd)
        csq_pkg::CMD_CREATE: begin
          if (live_q) begin
            status = csq_pkg::ST_ALREADY_LIVE;
          end else begin
            count_d      = in_q.init_value;
            q_ctrl.clear = 1'b1;
            live_d       = 1'b1;
          end
        end
        csq_pkg::CMD_DOWN: begin
          priority if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else if (total == csq_pkg::TotalBits'(csq_pkg::MaxWaiters)) begin
            status = csq_pkg::ST_FULL;
          end else begin
            q_ctrl.push = 1'b1;
            status      = csq_pkg::ST_WAIT;
          end
        end
        csq_pkg::CMD_UP: begin
          priority if (total != '0) begin
            q_ctrl.pop = 1'b1;
            woken      = 8'(head_data);
            status     = csq_pkg::ST_RELEASED;
          end else if (count_q != csq_pkg::CountMax) begin
            count_d = count_q + 1'b1;
          end
        end
        csq_pkg::CMD_DESTROY: begin
          if (total != '0) begin
            status = csq_pkg::ST_WAITERS;
          end else begin
            live_d = 1'b0;
          end
        end
        default: status = csq_pkg::ST_DONE;
      endcase
    end
    if (!advance) begin
      live_d  = live_q;
      count_d = count_q;
      q_ctrl  = '0;
    end
  end

  always_comb begin
    priority if (q_ctrl.clear) begin
      total_after = '0;
    end else if (q_ctrl.push) begin
      total_after = total + 1'b1;
    end else if (q_ctrl.pop) begin
      total_after = total - 1'b1;
    end else begin
      total_after = total;
    end
  end

  always_comb begin
    out_d.status       = status;
    out_d.woken_thread = woken;
    out_d.count_now    = count_d;
    out_d.waiters_now  = 5'(total_after);
  end

  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      live_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      live_q    <= live_d;
      count_q   <= count_d;
    end
  end

  // Input register is cleared so the decode never sees an unknown command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (accept) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

/* rtl/csq_checker.sv */
// ----------------------------------------------------------------------------
// csq_checker
// Port-level checks for the counting semaphore unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input csq_pkg::out_t out_o
);

  `ASSERT_IMPL(a_woken_only_on_release, clk_i, rst_ni, out_valid_o && out_o.status != csq_pkg::ST_RELEASED, out_o.woken_thread == '0, "woken thread set without a release")
  `ASSERT_IMPL(a_stall_from_output, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while the result side is free")
  `ASSERT_IMPL(a_wait_at_zero, clk_i, rst_ni, out_valid_o && (out_o.status == csq_pkg::ST_WAIT || out_o.status == csq_pkg::ST_FULL), out_o.count_now == '0, "caller queued while units remain")
  `ASSERT_IMPL(a_full_means_full, clk_i, rst_ni, out_valid_o && out_o.status == csq_pkg::ST_FULL, out_o.waiters_now == 5'(csq_pkg::MaxWaiters), "queue full reported on a partial queue")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o), "stalled result changed")

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
